// ----- design/iteration_count_colormap_assert.svh -----
// Assertion macros shared by the colormap pipeline modules.
`ifndef ITERATION_COUNT_COLORMAP_ASSERT_SVH
`define ITERATION_COUNT_COLORMAP_ASSERT_SVH

// When pre holds at a clock edge, post must hold at the same edge.
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// cond must never hold at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ----- design/icm_pkg.sv -----
// Shared constants, types and helper functions of the iteration count colormap.
package icm_pkg;

    localparam int COUNT_BITS    = 16;
    localparam int FRACTION_BITS = 24;
    localparam int CFG_BITS      = 16;

    localparam int T_BITS   = FRACTION_BITS + 1;
    localparam int REM_BITS = COUNT_BITS + 1;

    localparam int DIV_STEP   = 2;
    localparam int DIV_STAGES = (FRACTION_BITS + DIV_STEP - 1) / DIV_STEP;

    localparam logic [T_BITS-1:0] UNIT = T_BITS'(1) << FRACTION_BITS;

    localparam int SCALE_BITS = 13;
    localparam logic [SCALE_BITS-1:0] RED_SCALE   = SCALE_BITS'(9 * 255);
    localparam logic [SCALE_BITS-1:0] GREEN_SCALE = SCALE_BITS'(15 * 255);
    localparam logic [SCALE_BITS-1:0] BLUE_SCALE  = SCALE_BITS'(17 * 255);

    localparam int REG_INDEX_BITS = 1;
    localparam logic [REG_INDEX_BITS-1:0] REG_MAX_ITERATIONS = 1'd0;
    localparam logic [REG_INDEX_BITS-1:0] REG_COLOR_MODE     = 1'd1;

    localparam logic [CFG_BITS-1:0] MAX_ITERATIONS_RESET = CFG_BITS'(255);

    localparam logic MODE_LINEAR = 1'b0;
    localparam logic MODE_SMOOTH = 1'b1;

    // Partial division: remainder and quotient bits built so far.
    typedef struct packed {
        logic                valid;
        logic [REM_BITS-1:0] rem;
        logic [T_BITS-1:0]   quot;
    } icm_div_t;

    // Normalized count leaving the divider.
    typedef struct packed {
        logic              valid;
        logic [T_BITS-1:0] t;
    } icm_frac_t;

    // One finished color.
    typedef struct packed {
        logic       valid;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } icm_rgb_t;

    // Fractional product of two Q1.FRACTION_BITS values no larger than one.
    function automatic logic [T_BITS-1:0] frac_mul(logic [T_BITS-1:0] a,
                                                   logic [T_BITS-1:0] b);
        logic [2*T_BITS-1:0] p;
        p = {{T_BITS{1'b0}}, a} * {{T_BITS{1'b0}}, b};
        return p[FRACTION_BITS +: T_BITS];
    endfunction

    // Scale a fraction to a byte, saturating at full intensity.
    function automatic logic [7:0] scale_chan(logic [T_BITS-1:0]     p,
                                              logic [SCALE_BITS-1:0] k,
                                              int                    shift);
        logic [T_BITS+SCALE_BITS-1:0] prod;
        logic [T_BITS+SCALE_BITS-1:0] sh;
        prod = {{SCALE_BITS{1'b0}}, p} * {{T_BITS{1'b0}}, k};
        sh   = prod >> shift;
        if (sh > (T_BITS+SCALE_BITS)'(255))
            return 8'hFF;
        return sh[7:0];
    endfunction

endpackage

// ----- design/icm_divider.sv -----
// Pipelined restoring divider forming the fraction bits of count / limit.
`include "iteration_count_colormap_assert.svh"

module icm_divider
    import icm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [COUNT_BITS-1:0] lim,
    input  icm_div_t              div_in,
    output icm_frac_t             frac_out
);

    // Advance one stage: DIV_STEP quotient bits, starting at fraction bit base.
    function automatic icm_div_t div_step(icm_div_t d, logic [COUNT_BITS-1:0] l, int base);
        logic [REM_BITS-1:0] r;
        logic [REM_BITS-1:0] r2;
        logic [REM_BITS-1:0] le;
        logic [T_BITS-1:0]   q;
        icm_div_t            res;
        r  = d.rem;
        q  = d.quot;
        le = {1'b0, l};
        for (int k = 0; k < DIV_STEP; k++)
        begin
            if (base + k < FRACTION_BITS)
            begin
                r2 = {r[REM_BITS-2:0], 1'b0};
                if (r2 >= le)
                begin
                    r = r2 - le;
                    q[FRACTION_BITS-1-(base+k)] = 1'b1;
                end
                else
                begin
                    r = r2;
                end
            end
        end
        res.valid = d.valid;
        res.rem   = r;
        res.quot  = q;
        return res;
    endfunction

    icm_div_t            stage_in   [DIV_STAGES];
    icm_div_t            stage_next [DIV_STAGES];
    logic                valid_reg  [DIV_STAGES];
    logic [REM_BITS-1:0] rem_reg    [DIV_STAGES];
    logic [T_BITS-1:0]   quot_reg   [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_stage
        if (s == 0)
        begin : g_first
            assign stage_in[s] = div_in;
        end
        else
        begin : g_rest
            assign stage_in[s].valid = valid_reg[s-1];
            assign stage_in[s].rem   = rem_reg[s-1];
            assign stage_in[s].quot  = quot_reg[s-1];
        end

        assign stage_next[s] = div_step(stage_in[s], lim, s * DIV_STEP);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[s] <= 1'b0;
            else
                valid_reg[s] <= stage_next[s].valid;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s]  <= stage_next[s].rem;
            quot_reg[s] <= stage_next[s].quot;
        end
    end

    assign frac_out.valid = valid_reg[DIV_STAGES-1];
    assign frac_out.t     = quot_reg[DIV_STAGES-1];

    `ASSERT_IMPLIES(a_rem_below_lim, clk, rst_n, valid_reg[DIV_STAGES-1],
        rem_reg[DIV_STAGES-1] < {1'b0, lim}, "divider remainder not below limit")
    `ASSERT_IMPLIES(a_full_scale_exact, clk, rst_n,
        valid_reg[DIV_STAGES-1] && quot_reg[DIV_STAGES-1][FRACTION_BITS],
        rem_reg[DIV_STAGES-1] == '0, "full-scale quotient left a remainder")
    `ASSERT_IMPLIES(a_frac_range, clk, rst_n, frac_out.valid, frac_out.t <= UNIT,
        "normalized count above one")

endmodule

// ----- design/icm_palette.sv -----
// Palette pipeline: polynomial products, channel scaling and mode select.
`include "iteration_count_colormap_assert.svh"

module icm_palette
    import icm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      color_mode,
    input  icm_frac_t frac_in,
    output icm_rgb_t  rgb_out
);

    logic              p1_valid_reg;
    logic [T_BITS-1:0] p1_t_reg;
    logic [T_BITS-1:0] p1_u_reg;

    logic              p2_valid_reg;
    logic [T_BITS-1:0] p2_t_reg;
    logic [T_BITS-1:0] p2_u_reg;
    logic [T_BITS-1:0] p2_ut_reg;
    logic [T_BITS-1:0] p2_uu_reg;

    logic              p3_valid_reg;
    logic [T_BITS-1:0] p3_t_reg;
    logic [T_BITS-1:0] p3_utt_reg;
    logic [T_BITS-1:0] p3_uut_reg;
    logic [T_BITS-1:0] p3_uuu_reg;

    logic              p4_valid_reg;
    logic [T_BITS-1:0] p4_t_reg;
    logic [T_BITS-1:0] p4_pr_reg;
    logic [T_BITS-1:0] p4_pg_reg;
    logic [T_BITS-1:0] p4_pb_reg;

    logic       out_valid_reg;
    logic [7:0] out_red_reg;
    logic [7:0] out_green_reg;
    logic [7:0] out_blue_reg;

    logic [23:0] lin_word;
    logic [7:0]  red_next;
    logic [7:0]  green_next;
    logic [7:0]  blue_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            p4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg  <= frac_in.valid;
            p2_valid_reg  <= p1_valid_reg;
            p3_valid_reg  <= p2_valid_reg;
            p4_valid_reg  <= p3_valid_reg;
            out_valid_reg <= p4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_t_reg   <= frac_in.t;
        p1_u_reg   <= UNIT - frac_in.t;

        p2_t_reg   <= p1_t_reg;
        p2_u_reg   <= p1_u_reg;
        p2_ut_reg  <= frac_mul(p1_u_reg, p1_t_reg);
        p2_uu_reg  <= frac_mul(p1_u_reg, p1_u_reg);

        p3_t_reg   <= p2_t_reg;
        p3_utt_reg <= frac_mul(p2_ut_reg, p2_t_reg);
        p3_uut_reg <= frac_mul(p2_uu_reg, p2_t_reg);
        p3_uuu_reg <= frac_mul(p2_uu_reg, p2_u_reg);

        p4_t_reg   <= p3_t_reg;
        p4_pr_reg  <= frac_mul(p3_utt_reg, p3_t_reg);
        p4_pg_reg  <= frac_mul(p3_uut_reg, p3_t_reg);
        p4_pb_reg  <= frac_mul(p3_uuu_reg, p3_t_reg);

        out_red_reg   <= red_next;
        out_green_reg <= green_next;
        out_blue_reg  <= blue_next;
    end

    // Linear palette takes the low 24 bits of the 24-bit-scaled fraction.
    assign lin_word = p4_t_reg[FRACTION_BITS-24 +: 24];

    always_comb
    begin
        case (color_mode)
            MODE_SMOOTH:
            begin
                red_next   = scale_chan(p4_pr_reg, RED_SCALE, FRACTION_BITS);
                green_next = scale_chan(p4_pg_reg, GREEN_SCALE, FRACTION_BITS);
                blue_next  = scale_chan(p4_pb_reg, BLUE_SCALE, FRACTION_BITS + 1);
            end
            default:
            begin
                blue_next  = lin_word[23:16];
                red_next   = lin_word[15:8];
                green_next = lin_word[7:0];
            end
        endcase
    end

    assign rgb_out.valid = out_valid_reg;
    assign rgb_out.red   = out_red_reg;
    assign rgb_out.green = out_green_reg;
    assign rgb_out.blue  = out_blue_reg;

    `ASSERT_IMPLIES(a_unit_split, clk, rst_n, p1_valid_reg,
        (p1_u_reg + p1_t_reg) == UNIT, "u and t do not sum to one")
    `ASSERT_IMPLIES(a_ut_bound, clk, rst_n, p2_valid_reg, p2_ut_reg <= p2_t_reg,
        "product u*t exceeds t")
    `ASSERT_NEVER(a_uuu_bound, clk, rst_n, p3_valid_reg && (p3_uuu_reg > UNIT),
        "cubic term out of range")

endmodule

// ----- design/iteration_count_colormap.sv -----
// Throughput: one item per clock; busy stays low, so start is taken in every cycle.
// Each accepted start gives a result strobe (done), in order, after passing the clamp stage,
// the twelve two-bit stages of the pipelined divider, the u stage, three multiply stages
// and the output register, in that order.
// Reset (rst_n low, asynchronous) empties the pipeline and restores
// max_iterations to 255 and color_mode to linear.
module iteration_count_colormap
    import icm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [COUNT_BITS-1:0]     iteration_count,
    input  logic                      wr_en,
    input  logic [REG_INDEX_BITS-1:0] wr_index,
    input  logic [CFG_BITS-1:0]       wr_data,
    output logic                      done,
    output logic [7:0]                red,
    output logic [7:0]                green,
    output logic [7:0]                blue
);

    logic [CFG_BITS-1:0]   max_iterations_reg;
    logic                  color_mode_reg;

    logic [COUNT_BITS-1:0] lim_trunc;
    logic [COUNT_BITS-1:0] lim;
    logic                  at_limit;

    logic                  s0_valid_reg;
    logic [REM_BITS-1:0]   s0_rem_reg;
    logic [T_BITS-1:0]     s0_quot_reg;

    icm_div_t              div_in;
    icm_frac_t             frac;
    icm_rgb_t              rgb;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iterations_reg <= MAX_ITERATIONS_RESET;
            color_mode_reg     <= MODE_LINEAR;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_MAX_ITERATIONS: max_iterations_reg <= wr_data;
                REG_COLOR_MODE:     color_mode_reg     <= wr_data[0];
                default:            ;
            endcase
        end
    end

    // Treat a zero limit as one.
    assign lim_trunc = COUNT_BITS'(max_iterations_reg);
    assign lim       = (lim_trunc == '0) ? COUNT_BITS'(1) : lim_trunc;
    assign at_limit  = (iteration_count >= lim);

    // Clamp stage: a count at or above the limit is exactly one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else
            s0_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        s0_rem_reg  <= at_limit ? '0 : {1'b0, iteration_count};
        s0_quot_reg <= at_limit ? UNIT : '0;
    end

    assign div_in.valid = s0_valid_reg;
    assign div_in.rem   = s0_rem_reg;
    assign div_in.quot  = s0_quot_reg;

    icm_divider u_divider
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .lim      (lim),
        .div_in   (div_in),
        .frac_out (frac)
    );

    icm_palette u_palette
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .color_mode (color_mode_reg),
        .frac_in    (frac),
        .rgb_out    (rgb)
    );

    assign done  = rgb.valid;
    assign red   = rgb.red;
    assign green = rgb.green;
    assign blue  = rgb.blue;

endmodule

// ----- tb/iteration_count_colormap_tb.sv -----
// Self-checking testbench for the escape-time count to RGB colormap.
`timescale 1ns / 100ps

module iteration_count_colormap_tb;
    import icm_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int LATENCY       = 17;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 125;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic [COUNT_BITS-1:0]     iteration_count = '0;
    logic                      wr_en = 1'b0;
    logic [REG_INDEX_BITS-1:0] wr_index = REG_MAX_ITERATIONS;
    logic [CFG_BITS-1:0]       wr_data = '0;
    logic                      done;
    logic [7:0]                red;
    logic [7:0]                green;
    logic [7:0]                blue;

    logic [COUNT_BITS-1:0] queued_counts[$];
    pixel_t                predicted_pixels[$];
    pixel_t                oldest_pixel;

    logic [15:0] cfg_max = 16'd255;
    logic        cfg_mode = MODE_LINEAR;
    int          idle_pct = 31;
    int          items_issued = 0;
    int          results_seen = 0;
    int          errors = 0;
    int          cycle_count = 0;

    iteration_count_colormap u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .iteration_count (iteration_count),
        .wr_en           (wr_en),
        .wr_index        (wr_index),
        .wr_data         (wr_data),
        .done            (done),
        .red             (red),
        .green           (green),
        .blue            (blue)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Truncated product of two unsigned Q1.24 fractions.
    function automatic logic [63:0] frac_product(logic [63:0] a, logic [63:0] b);
        return (a * b) >> FRACTION_BITS;
    endfunction

    function automatic pixel_t colorize(logic [15:0] count, logic [15:0] limit_reg,
                                        logic mode);
        logic [63:0] lim;
        logic [63:0] cnt;
        logic [63:0] t;
        logic [63:0] u;
        logic [63:0] pr;
        logic [63:0] pg;
        logic [63:0] pb;
        logic [63:0] r;
        logic [63:0] g;
        logic [63:0] b;
        pixel_t      px;
        lim = {48'd0, limit_reg};
        cnt = {48'd0, count};
        if (lim == 0)
            lim = 1;
        if (cnt > lim)
            cnt = lim;
        t = (cnt << FRACTION_BITS) / lim;
        if (mode == MODE_LINEAR)
        begin
            // top count gives t = 1.0, whose low 24 bits are zero
            px.blue  = t[23:16];
            px.red   = t[15:8];
            px.green = t[7:0];
        end
        else
        begin
            u  = (64'd1 << FRACTION_BITS) - t;
            pr = frac_product(frac_product(frac_product(u, t), t), t);
            pg = frac_product(frac_product(frac_product(u, u), t), t);
            pb = frac_product(frac_product(frac_product(u, u), u), t);
            r  = (pr * (9 * 255)) >> FRACTION_BITS;
            g  = (pg * (15 * 255)) >> FRACTION_BITS;
            b  = (pb * (17 * 255)) >> (FRACTION_BITS + 1);
            px.red   = (r > 255) ? 8'hFF : r[7:0];
            px.green = (g > 255) ? 8'hFF : g[7:0];
            px.blue  = (b > 255) ? 8'hFF : b[7:0];
        end
        return px;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("MISMATCH %s: expected %0d, got %0d (cycle %0d)", what, want, got,
                 cycle_count);
        errors++;
    endtask

    // Driver: predict each accepted item, then offer the next one unless idling.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                predicted_pixels.push_back(colorize(iteration_count, cfg_max, cfg_mode));
            if (!(start && busy))
            begin
                if (queued_counts.size() > 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    start           <= 1'b1;
                    iteration_count <= queued_counts.pop_front();
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare every strobed color with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            results_seen <= results_seen + 1;
            if (predicted_pixels.size() == 0)
            begin
                report_mismatch("color with no item pending, red", 0, red);
            end
            else
            begin
                oldest_pixel = predicted_pixels.pop_front();
                if (red !== oldest_pixel.red)
                    report_mismatch("red", oldest_pixel.red, red);
                if (green !== oldest_pixel.green)
                    report_mismatch("green", oldest_pixel.green, green);
                if (blue !== oldest_pixel.blue)
                    report_mismatch("blue", oldest_pixel.blue, blue);
            end
        end
    end

    task automatic push_count(input logic [COUNT_BITS-1:0] count);
        queued_counts.push_back(count);
        items_issued++;
    endtask

    // Hold until every issued item has come back as a color.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (results_seen != items_issued || queued_counts.size() != 0);
    endtask

    task automatic program_regs(input logic [CFG_BITS-1:0] max_data,
                                input logic [CFG_BITS-1:0] mode_data);
        wait_drained();
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= REG_MAX_ITERATIONS;
        wr_data  <= max_data;
        cfg_max   = max_data;
        @(posedge clk);
        wr_index <= REG_COLOR_MODE;
        wr_data  <= mode_data;
        cfg_mode  = mode_data[0];
        @(posedge clk);
        wr_en    <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        logic [CFG_BITS-1:0] max_data;
        logic [CFG_BITS-1:0] mode_data;
        logic [15:0]         count;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset values: limit 255, linear palette
        idle_pct = 31;
        push_count(16'd0);
        push_count(16'd1);
        push_count(16'd127);
        push_count(16'd128);
        push_count(16'd254);
        push_count(16'd255);
        push_count(16'd256);
        push_count(16'hFFFF);

        // zero limit acts as one; upper mode bits are ignored
        program_regs(16'd0, 16'hFFFE);
        push_count(16'd0);
        push_count(16'd1);
        push_count(16'd2);
        push_count(16'hFFFF);

        program_regs(16'hFFFF, 16'hAAAB);
        push_count(16'd0);
        push_count(16'd1);
        push_count(16'h8000);
        push_count(16'hFFFE);
        push_count(16'hFFFF);
        push_count(16'h5555);

        program_regs(16'd1, {15'h5555, MODE_SMOOTH});
        push_count(16'd0);
        push_count(16'd1);
        push_count(16'hFFFF);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case ($urandom_range(0, 3))
                0: max_data = CFG_BITS'($urandom_range(1, 16));
                1: max_data = CFG_BITS'($urandom);
                2: max_data = $urandom_range(0, 1) ? 16'hFFFF : 16'd1;
                default: max_data = CFG_BITS'($urandom_range(200, 2000));
            endcase
            mode_data = CFG_BITS'($urandom);
            // make sure both palettes get at least one random phase
            if (phase < 2)
                mode_data[0] = phase[0];
            program_regs(max_data, mode_data);
            idle_pct = (phase < 4) ? 31 : (phase < 8) ? 77 : 0;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                case ($urandom_range(0, 9))
                    7: count = cfg_max + 16'($urandom_range(0, 2)) - 16'd1;
                    8, 9: count = 16'($urandom);
                    default: count = 16'($urandom_range(0, cfg_max));
                endcase
                push_count(count);
            end
        end

        wait_drained();
        repeat (LATENCY + 8) @(posedge clk);
        if (predicted_pixels.size() != 0)
            report_mismatch("colors never delivered", 0, predicted_pixels.size());
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
